>>> sv/sbpp_pkg.sv
// Shared types and constants for the sorted buffer with parity-selective pop.
`timescale 1ns / 1ps

package sbpp_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 8;
    localparam int STATUS_BITS    = 3;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_MISMATCH = 3'd4
    } t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

>>> sv/sbpp_cell.sv
// One storage cell of the sorted shift chain.
`timescale 1ns / 1ps

module sbpp_cell #(
    parameter int VALUE_BITS = sbpp_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  sbpp_pkg::t_cell_ctrl  i_ctrl,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_occupied,
    input  logic                  i_prev_keep,
    input  logic [VALUE_BITS-1:0] i_prev_data,
    input  logic [VALUE_BITS-1:0] i_next_data,
    output logic                  o_keep,
    output logic [VALUE_BITS-1:0] o_data
);
    import sbpp_pkg::*;

    logic [VALUE_BITS-1:0] r_data;
    logic [VALUE_BITS-1:0] n_data;

    assign o_keep = i_occupied && (r_data < i_value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.insert && !o_keep) begin
            n_data = i_prev_keep ? i_value : i_prev_data;
        end else if (i_ctrl.remove) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

>>> sv/sorted_buffer_parity_pop_top.sv
// Top level of the sorted buffer with parity-selective pop.
`timescale 1ns / 1ps

// The buffer holds up to CAPACITY values in ascending order in a chain of cells, one value
// per cell. It takes one insert or remove transfer per cycle while its output register is
// free or read, and delivers the result in the next cycle from that register; input ready
// follows output ready, so while a result waits unread no new item is taken. Each cell
// compares its value with the incoming one, shifts toward the tail on an insert or toward
// the head on a remove, all in the same cycle; one compare per cell and the head parity
// check bound that rate. Entries past the count are never read, need no clearing after reset.
module sorted_buffer_parity_pop_top #(
    parameter int CAPACITY   = sbpp_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sbpp_pkg::VALUE_BITS_DEF,
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_operation,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_want_odd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sbpp_pkg::t_status     o_status,
    output logic [VALUE_BITS-1:0] o_removed_value,
    output logic [CW-1:0]         o_occupancy
);
    import sbpp_pkg::*;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_match;
    t_cell_ctrl            w_ctrl;
    logic [VALUE_BITS-1:0] w_data [CAPACITY];
    logic                  w_keep [CAPACITY];

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [VALUE_BITS-1:0] r_removed;
    logic [VALUE_BITS-1:0] n_removed;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_match  = (w_data[0][0] == i_want_odd);

    assign w_ctrl.insert = w_accept && (i_operation == OP_INSERT) && !w_full;
    assign w_ctrl.remove = w_accept && (i_operation == OP_REMOVE) && !w_empty && w_match;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                  w_prev_keep;
            logic [VALUE_BITS-1:0] w_prev_data;
            logic [VALUE_BITS-1:0] w_next_data;

            if (gi == 0) begin : g_head
                assign w_prev_keep = 1'b1;
                assign w_prev_data = i_value;
            end else begin : g_body
                assign w_prev_keep = w_keep[gi-1];
                assign w_prev_data = w_data[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_next_data = w_data[gi];
            end else begin : g_inner
                assign w_next_data = w_data[gi+1];
            end

            sbpp_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_value     (i_value),
                .i_occupied  (CW'(gi) < r_count),
                .i_prev_keep (w_prev_keep),
                .i_prev_data (w_prev_data),
                .i_next_data (w_next_data),
                .o_keep      (w_keep[gi]),
                .o_data      (w_data[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        if (i_operation == OP_INSERT) begin
            n_status = w_full ? ST_FULL : ST_INSERTED;
        end else if (w_empty) begin
            n_status = ST_EMPTY;
        end else if (!w_match) begin
            n_status = ST_MISMATCH;
        end else begin
            n_status  = ST_REMOVED;
            n_removed = w_data[0];
        end
        if (w_ctrl.insert) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.remove) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_occupancy     = r_count;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the sorted buffer with parity-selective pop.
`timescale 1ns / 1ps

module tb_top;
    import sbpp_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int CW         = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 1600;

    typedef struct {
        t_status               status;
        logic [VALUE_BITS-1:0] removed_value;
        logic [CW-1:0]         occupancy;
    } t_buffer_result;

    class sorted_buffer_scoreboard;
        logic [VALUE_BITS-1:0] held_values[$];
        t_buffer_result        pending_results[$];
        int                    errors;
        int                    status_count[5];
        int                    checked;

        function new();
            errors  = 0;
            checked = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function bit head_is_odd();
            if (held_values.size() == 0) begin
                return 1'($urandom_range(0, 1));
            end
            return held_values[0][0];
        endfunction

        function void note_input(logic op, logic [VALUE_BITS-1:0] value, logic want_odd);
            t_buffer_result outcome;
            int             pos;
            outcome.removed_value = '0;
            if (op == OP_INSERT) begin
                if (held_values.size() >= CAPACITY) begin
                    outcome.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_values.size() && held_values[pos] < value) pos++;
                    held_values.insert(pos, value);
                    outcome.status = ST_INSERTED;
                end
            end else if (held_values.size() == 0) begin
                outcome.status = ST_EMPTY;
            end else if (held_values[0][0] != want_odd) begin
                outcome.status = ST_MISMATCH;
            end else begin
                outcome.removed_value = held_values.pop_front();
                outcome.status        = ST_REMOVED;
            end
            outcome.occupancy = CW'(held_values.size());
            status_count[int'(outcome.status)]++;
            pending_results.push_back(outcome);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_status status, logic [VALUE_BITS-1:0] removed_value,
                          logic [CW-1:0] occupancy);
            t_buffer_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing outstanding, status %0d", status));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (status !== want.status) begin
                report($sformatf("status %0d, expected %0d", status, want.status));
            end
            if (removed_value !== want.removed_value) begin
                report($sformatf("removed value %0d, expected %0d",
                                 removed_value, want.removed_value));
            end
            if (occupancy !== want.occupancy) begin
                report($sformatf("occupancy %0d, expected %0d", occupancy, want.occupancy));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_operation;
    logic [VALUE_BITS-1:0] i_value;
    logic                  i_want_odd;
    logic                  o_valid;
    logic                  i_ready;
    t_status               o_status;
    logic [VALUE_BITS-1:0] o_removed_value;
    logic [CW-1:0]         o_occupancy;

    sorted_buffer_scoreboard sb;
    int                      items_sent;

    sorted_buffer_parity_pop_top #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .i_want_odd      (i_want_odd),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task send_item(logic op, logic [VALUE_BITS-1:0] value, logic want_odd, bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap) begin
            while ($urandom_range(0, 99) < 24) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= value;
        i_want_odd  <= want_odd;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(op, value, want_odd);
        items_sent++;
    endtask

    function logic [VALUE_BITS-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return VALUE_BITS'($urandom_range(0, 7));
        if (sel < 30) return '1;
        if (sel < 33) return '0;
        return VALUE_BITS'($urandom());
    endfunction

    task send_random_item(int index);
        int   phase;
        int   remove_pct;
        int   match_pct;
        logic op;
        logic want_odd;
        phase = (index / 150) % 4;
        case (phase)
            0: begin
                remove_pct = 12;
                match_pct  = 85;
            end
            1: begin
                remove_pct = 85;
                match_pct  = 85;
            end
            2: begin
                remove_pct = 50;
                match_pct  = 70;
            end
            default: begin
                remove_pct = 50;
                match_pct  = 50;
            end
        endcase
        op = ($urandom_range(0, 99) < remove_pct) ? OP_REMOVE : OP_INSERT;
        if ($urandom_range(0, 99) < match_pct) begin
            want_odd = sb.head_is_odd();
        end else begin
            want_odd = 1'($urandom_range(0, 1));
        end
        send_item(op, pick_value(), want_odd, !(index >= 700 && index < 1000));
    endtask

    initial begin : stimulus
        sb          = new();
        items_sent  = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_INSERT;
        i_value     = '0;
        i_want_odd  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_REMOVE, '0, 1'b0, 1'b1);
        send_item(OP_REMOVE, '1, 1'b1, 1'b1);
        send_item(OP_INSERT, '1, 1'b0, 1'b1);
        send_item(OP_INSERT, '0, 1'b1, 1'b1);
        send_item(OP_INSERT, '0, 1'b0, 1'b1);
        send_item(OP_INSERT, 8'd128, 1'b0, 1'b1);
        send_item(OP_INSERT, 8'd127, 1'b1, 1'b1);
        send_item(OP_REMOVE, '1, 1'b1, 1'b1);
        send_item(OP_REMOVE, '1, 1'b0, 1'b1);
        send_item(OP_REMOVE, '0, 1'b0, 1'b1);
        send_item(OP_REMOVE, '0, 1'b0, 1'b1);
        send_item(OP_REMOVE, '0, 1'b1, 1'b0);
        send_item(OP_REMOVE, '0, 1'b1, 1'b0);
        send_item(OP_REMOVE, '0, 1'b0, 1'b0);
        send_item(OP_REMOVE, '0, 1'b0, 1'b0);
        send_item(OP_REMOVE, '0, 1'b1, 1'b0);
        send_item(OP_REMOVE, '0, 1'b1, 1'b1);
        send_item(OP_INSERT, 8'h55, 1'b0, 1'b1);
        send_item(OP_INSERT, 8'hAA, 1'b1, 1'b1);
        send_item(OP_REMOVE, '0, 1'b0, 1'b1);
        send_item(OP_REMOVE, '0, 1'b1, 1'b1);
        send_item(OP_REMOVE, '0, 1'b0, 1'b1);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            send_random_item(k);
        end
        i_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d transfers: %0d inserts, %0d removes, %0d full refusals,",
                 items_sent, sb.status_count[int'(ST_INSERTED)],
                 sb.status_count[int'(ST_REMOVED)], sb.status_count[int'(ST_FULL)]);
        $display("%0d empty refusals and %0d parity mismatches; %0d results checked.",
                 sb.status_count[int'(ST_EMPTY)], sb.status_count[int'(ST_MISMATCH)],
                 sb.checked);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : receiver
        int unsigned rx_cycle;
        i_ready  = 1'b0;
        rx_cycle = 0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_cycle >= 1000 && rx_cycle < 1300) begin
                i_ready <= 1'b0;
            end else if (rx_cycle >= 1600 && rx_cycle < 2000) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 24);
            end
            @(posedge i_clk);
            rx_cycle++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_status, o_removed_value, o_occupancy);
        end
    end

    initial begin : run_limit
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/sbpp_pkg.sv
sv/sbpp_cell.sv
sv/sorted_buffer_parity_pop_top.sv
verif/tb_top.sv
